>>> hdl/led_matrix_scan_mode_controller_top_defines.svh
// Assertion macros for the LED matrix scan and display-mode controller.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef LED_MATRIX_SCAN_MODE_CONTROLLER_TOP_DEFINES_SVH
`define LED_MATRIX_SCAN_MODE_CONTROLLER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMSMC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LMSMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/lmsmc_pkg.sv
// Package for the LED matrix scan and display-mode controller.
// Holds item kinds, display-mode codes, register indexes and result types; no dependencies.
package lmsmc_pkg;

	localparam int ROWS_DEF    = 8;
	localparam int COLUMNS_DEF = 24;
	localparam int FRAMES_DEF  = 8;

	localparam logic [7:0]  SCROLL_PERIOD_RST     = 8'd50;
	localparam logic [4:0]  LAST_SCROLL_STEP_RST  = 5'd23;
	localparam logic [9:0]  BLINK_HALF_PERIOD_RST = 10'd400;
	localparam logic [15:0] INIT_HOLD_TICKS_RST   = 16'd2000;
	localparam logic [9:0]  TICKS_PER_SECOND_RST  = 10'd1000;

	typedef enum logic [1:0] {
		KIND_TICK          = 2'd0,
		KIND_ROW_WRITE     = 2'd1,
		KIND_SET_MODE      = 2'd2,
		KIND_SET_STOPWATCH = 2'd3
	} item_kind_t;

	typedef enum logic [2:0] {
		REG_SCROLL_PERIOD     = 3'd0,
		REG_LAST_SCROLL_STEP  = 3'd1,
		REG_BLINK_HALF_PERIOD = 3'd2,
		REG_INIT_HOLD_TICKS   = 3'd3,
		REG_TICKS_PER_SECOND  = 3'd4
	} cfg_reg_t;

	localparam logic [2:0] MODE_IDLE             = 3'd0;
	localparam logic [2:0] MODE_STATIC           = 3'd1;
	localparam logic [2:0] MODE_SCROLL_TO_STATIC = 3'd2;
	localparam logic [2:0] MODE_SCROLL_TO_IDLE   = 3'd3;
	localparam logic [2:0] MODE_STARTUP          = 3'd5;
	localparam logic [2:0] MODE_STARTUP_SCROLL   = 3'd6;
	localparam logic [2:0] MODE_STOPWATCH        = 3'd7;

	localparam logic [15:0] SECONDS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [6:0] minutes_tens;
		logic [3:0] minutes_units;
		logic [2:0] seconds_tens;
		logic [3:0] seconds_units;
	} digits_t;

	typedef struct packed {
		logic        drive_valid;
		logic [2:0]  row_select;
		logic        col_ok;
		logic [2:0]  display_mode;
		logic [4:0]  scroll_step;
		logic        blink;
		logic [15:0] tick_count;
		digits_t     digits;
	} result_t;

endpackage

>>> hdl/led_matrix_scan_mode_controller_top.sv
// Top level of the LED matrix scan and display-mode controller.
// Depends on lmsmc_pkg and led_matrix_scan_mode_controller_top_defines.svh.
//
// Channel   Handshake              Payload
// in        in_valid / in_ready    mode, frame_index, row_index, row_bits, new_display_mode,
//                                  run_flag, clear_stopwatch
// out       out_valid / out_ready  drive_valid, row_select, column_bits, display_mode,
//                                  scroll_step, blink, tick_count, digit fields
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled; a result passes through the
// registered read of the frame memory and then the output register.
// Reset clears all counters and the frame valid bits at once; no clearing pass is run.
// A stalled output holds in the output register while one more transaction is taken.
// The configuration channel is always ready.
`include "led_matrix_scan_mode_controller_top_defines.svh"

module led_matrix_scan_mode_controller_top #(
	parameter int ROWS    = lmsmc_pkg::ROWS_DEF,
	parameter int COLUMNS = lmsmc_pkg::COLUMNS_DEF,
	parameter int FRAMES  = lmsmc_pkg::FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [2:0]         frame_index,
	input  logic [2:0]         row_index,
	input  logic [COLUMNS-1:0] row_bits,
	input  logic [2:0]         new_display_mode,
	input  logic               run_flag,
	input  logic               clear_stopwatch,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               drive_valid,
	output logic [2:0]         row_select,
	output logic [COLUMNS-1:0] column_bits,
	output logic [2:0]         display_mode,
	output logic [4:0]         scroll_step,
	output logic               blink,
	output logic [15:0]        tick_count,
	output logic [6:0]         minutes_tens,
	output logic [3:0]         minutes_units,
	output logic [2:0]         seconds_tens,
	output logic [3:0]         seconds_units,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import lmsmc_pkg::*;

	localparam int DEPTH = FRAMES * ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(ROWS);

	logic [7:0]  scroll_period_q;
	logic [4:0]  last_scroll_step_q;
	logic [9:0]  blink_half_period_q;
	logic [15:0] init_hold_ticks_q;
	logic [9:0]  ticks_per_second_q;

	logic [RW-1:0] scan_row_q, scan_row_d;
	logic [2:0]    mode_q, mode_d;
	logic [15:0]   tick_q, tick_d;
	logic [7:0]    stc_q, stc_d;
	logic [4:0]    idx_q, idx_d;
	logic          blink_q, blink_d;
	logic [9:0]    bc_q, bc_d;
	logic [15:0]   init_q, init_d;
	logic          running_q, running_d;
	logic [9:0]    ms_q, ms_d;
	logic [15:0]   sec_q, sec_d;
	digits_t       shadow_q, shadow_d, shadow_inc;
	digits_t       digits_q, digits_d;

	logic [COLUMNS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic               wr_en, rd_en, frame_ok;

	logic               in_accept, s1_adv;
	logic               s1_valid, s2_valid;
	result_t            res_d, res_s1, res_s2;
	logic [COLUMNS-1:0] rd_data_s1, column_bits_s2;

	assign cfg_ready = 1'b1;
	assign s1_adv    = !s2_valid || out_ready;
	assign in_ready  = !s1_valid || s1_adv;
	assign in_accept = in_valid && in_ready;

	assign wr_addr  = AW'(int'(frame_index) * ROWS + int'(row_index));
	assign rd_addr  = AW'(int'(mode_q) * ROWS + int'(scan_row_q));
	assign frame_ok = int'(mode_q) < FRAMES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_period_q     <= SCROLL_PERIOD_RST;
			last_scroll_step_q  <= LAST_SCROLL_STEP_RST;
			blink_half_period_q <= BLINK_HALF_PERIOD_RST;
			init_hold_ticks_q   <= INIT_HOLD_TICKS_RST;
			ticks_per_second_q  <= TICKS_PER_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCROLL_PERIOD:     scroll_period_q     <= cfg_data[7:0];
				REG_LAST_SCROLL_STEP:  last_scroll_step_q  <= cfg_data[4:0];
				REG_BLINK_HALF_PERIOD: blink_half_period_q <= cfg_data[9:0];
				REG_INIT_HOLD_TICKS:   init_hold_ticks_q   <= cfg_data;
				REG_TICKS_PER_SECOND:  ticks_per_second_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// The shadow digits track the seconds count sec_q, so no division is needed.
	always_comb begin
		shadow_inc = shadow_q;
		if (sec_q == SECONDS_MAX) begin
			shadow_inc = '0;
		end else if (shadow_q.seconds_units != 4'd9) begin
			shadow_inc.seconds_units = shadow_q.seconds_units + 4'd1;
		end else begin
			shadow_inc.seconds_units = '0;
			if (shadow_q.seconds_tens != 3'd5) begin
				shadow_inc.seconds_tens = shadow_q.seconds_tens + 3'd1;
			end else begin
				shadow_inc.seconds_tens = '0;
				if (shadow_q.minutes_units != 4'd9) begin
					shadow_inc.minutes_units = shadow_q.minutes_units + 4'd1;
				end else begin
					shadow_inc.minutes_units = '0;
					shadow_inc.minutes_tens  = shadow_q.minutes_tens + 7'd1;
				end
			end
		end
	end

	always_comb begin
		logic [7:0]  stc_t;
		logic [9:0]  bc_inc;
		logic [9:0]  ms_inc;
		logic [15:0] init_inc;
		logic [2:0]  mode_t;
		stc_t      = stc_q;
		bc_inc     = bc_q + 10'd1;
		ms_inc     = ms_q + 10'd1;
		init_inc   = init_q + 16'd1;
		mode_t     = mode_q;
		scan_row_d = scan_row_q;
		mode_d     = mode_q;
		tick_d     = tick_q;
		stc_d      = stc_q;
		idx_d      = idx_q;
		blink_d    = blink_q;
		bc_d       = bc_q;
		init_d     = init_q;
		running_d  = running_q;
		ms_d       = ms_q;
		sec_d      = sec_q;
		shadow_d   = shadow_q;
		digits_d   = digits_q;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		if (in_accept) begin
			unique case (item_kind_t'(mode))
				KIND_TICK: begin
					rd_en      = frame_ok;
					scan_row_d = (scan_row_q == RW'(ROWS - 1)) ? '0 : scan_row_q + 1'b1;
					tick_d     = tick_q + 16'd1;
					if (mode_q == MODE_SCROLL_TO_STATIC || mode_q == MODE_SCROLL_TO_IDLE ||
					    mode_q == MODE_STARTUP_SCROLL) begin
						if (stc_q == scroll_period_q) begin
							stc_t = '0;
							if (idx_q == last_scroll_step_q) begin
								idx_d  = '0;
								mode_t = (mode_q == MODE_SCROLL_TO_STATIC) ? MODE_STATIC
								                                           : MODE_IDLE;
							end else begin
								idx_d = idx_q + 5'd1;
							end
						end
					end else begin
						stc_t = '0;
						idx_d = '0;
					end
					stc_d = stc_t + 8'd1;
					if (bc_inc == blink_half_period_q) begin
						bc_d    = '0;
						blink_d = !blink_q;
					end else begin
						bc_d = bc_inc;
					end
					if (mode_q == MODE_STARTUP) begin
						init_d = init_inc;
						if (init_inc == init_hold_ticks_q) begin
							mode_t = MODE_STARTUP_SCROLL;
						end
					end
					mode_d = mode_t;
					if (mode_q == MODE_STOPWATCH) begin
						if (running_q) begin
							if (ms_inc >= ticks_per_second_q) begin
								ms_d     = '0;
								sec_d    = sec_q + 16'd1;
								shadow_d = shadow_inc;
							end else begin
								ms_d = ms_inc;
							end
						end
						digits_d = shadow_d;
					end
				end
				KIND_ROW_WRITE: begin
					wr_en = (int'(frame_index) < FRAMES) && (int'(row_index) < ROWS);
				end
				KIND_SET_MODE: begin
					mode_d = new_display_mode;
				end
				KIND_SET_STOPWATCH: begin
					running_d = run_flag;
					if (clear_stopwatch) begin
						sec_d    = '0;
						ms_d     = '0;
						shadow_d = '0;
					end
				end
			endcase
		end
	end

	always_comb begin
		res_d              = '0;
		res_d.drive_valid  = item_kind_t'(mode) == KIND_TICK;
		res_d.row_select   = res_d.drive_valid ? 3'(scan_row_q) : 3'd0;
		res_d.col_ok       = res_d.drive_valid && frame_ok && vld_q[rd_addr];
		res_d.display_mode = mode_d;
		res_d.scroll_step  = idx_d;
		res_d.blink        = blink_d;
		res_d.tick_count   = tick_d;
		res_d.digits       = digits_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			mode_q     <= '0;
			tick_q     <= '0;
			stc_q      <= '0;
			idx_q      <= '0;
			blink_q    <= 1'b0;
			bc_q       <= '0;
			init_q     <= '0;
			running_q  <= 1'b0;
			ms_q       <= '0;
			sec_q      <= '0;
			shadow_q   <= '0;
			digits_q   <= '0;
			vld_q      <= '0;
		end else begin
			scan_row_q <= scan_row_d;
			mode_q     <= mode_d;
			tick_q     <= tick_d;
			stc_q      <= stc_d;
			idx_q      <= idx_d;
			blink_q    <= blink_d;
			bc_q       <= bc_d;
			init_q     <= init_d;
			running_q  <= running_d;
			ms_q       <= ms_d;
			sec_q      <= sec_d;
			shadow_q   <= shadow_d;
			digits_q   <= digits_d;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= row_bits;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_s1 <= res_d;
		end
		if (s1_adv && s1_valid) begin
			res_s2         <= res_s1;
			column_bits_s2 <= res_s1.col_ok ? rd_data_s1 : '0;
		end
	end

	assign out_valid     = s2_valid;
	assign drive_valid   = res_s2.drive_valid;
	assign row_select    = res_s2.row_select;
	assign column_bits   = column_bits_s2;
	assign display_mode  = res_s2.display_mode;
	assign scroll_step   = res_s2.scroll_step;
	assign blink         = res_s2.blink;
	assign tick_count    = res_s2.tick_count;
	assign minutes_tens  = res_s2.digits.minutes_tens;
	assign minutes_units = res_s2.digits.minutes_units;
	assign seconds_tens  = res_s2.digits.seconds_tens;
	assign seconds_units = res_s2.digits.seconds_units;

	`LMSMC_ASSERT_SAME(a_idle_out_ready_in, !out_valid, in_ready, "input stalled with empty output")
	`LMSMC_ASSERT_SAME(a_no_drive_blank, out_valid && !drive_valid,
		row_select == 3'd0 && column_bits == '0, "non-tick result drives the matrix")
	`LMSMC_ASSERT_SAME(a_digit_range, s2_valid,
		seconds_units <= 4'd9 && seconds_tens <= 3'd5 && minutes_units <= 4'd9,
		"stopwatch digit out of range")
	`LMSMC_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_adv, s1_valid, "stalled transaction dropped")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for led_matrix_scan_mode_controller_top.
// Drives ticks, frame-row writes, mode and stopwatch sets under random flow control and
// checks every result against a cycle-free predictor; depends only on lmsmc_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lmsmc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned PRINT_CAP   = 40;

	typedef struct packed {
		item_kind_t             kind;
		logic [2:0]             frame;
		logic [2:0]             row;
		logic [COLUMNS_DEF-1:0] bits;
		logic [2:0]             new_mode;
		logic                   run;
		logic                   clr;
	} matrix_item_t;

	typedef struct packed {
		logic                   drive_valid;
		logic [2:0]             row_select;
		logic [COLUMNS_DEF-1:0] column_bits;
		logic [2:0]             display_mode;
		logic [4:0]             scroll_step;
		logic                   blink;
		logic [15:0]            tick_count;
		digits_t                digits;
	} matrix_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	matrix_item_t           bus_item  = '0;
	logic [1:0]             mode;
	logic [2:0]             frame_index;
	logic [2:0]             row_index;
	logic [COLUMNS_DEF-1:0] row_bits;
	logic [2:0]             new_display_mode;
	logic                   run_flag;
	logic                   clear_stopwatch;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   drive_valid;
	logic [2:0]             row_select;
	logic [COLUMNS_DEF-1:0] column_bits;
	logic [2:0]             display_mode;
	logic [4:0]             scroll_step;
	logic                   blink;
	logic [15:0]            tick_count;
	logic [6:0]             minutes_tens;
	logic [3:0]             minutes_units;
	logic [2:0]             seconds_tens;
	logic [3:0]             seconds_units;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [2:0]             cfg_index = '0;
	logic [15:0]            cfg_data  = '0;

	assign mode             = bus_item.kind;
	assign frame_index      = bus_item.frame;
	assign row_index        = bus_item.row;
	assign row_bits         = bus_item.bits;
	assign new_display_mode = bus_item.new_mode;
	assign run_flag         = bus_item.run;
	assign clear_stopwatch  = bus_item.clr;

	led_matrix_scan_mode_controller_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.frame_index      (frame_index),
		.row_index        (row_index),
		.row_bits         (row_bits),
		.new_display_mode (new_display_mode),
		.run_flag         (run_flag),
		.clear_stopwatch  (clear_stopwatch),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.drive_valid      (drive_valid),
		.row_select       (row_select),
		.column_bits      (column_bits),
		.display_mode     (display_mode),
		.scroll_step      (scroll_step),
		.blink            (blink),
		.tick_count       (tick_count),
		.minutes_tens     (minutes_tens),
		.minutes_units    (minutes_units),
		.seconds_tens     (seconds_tens),
		.seconds_units    (seconds_units),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the controller registers and state.
	logic [7:0]             set_scroll_period = SCROLL_PERIOD_RST;
	logic [4:0]             set_last_step     = LAST_SCROLL_STEP_RST;
	logic [9:0]             set_blink_half    = BLINK_HALF_PERIOD_RST;
	logic [15:0]            set_startup_hold  = INIT_HOLD_TICKS_RST;
	logic [9:0]             set_ms_per_sec    = TICKS_PER_SECOND_RST;

	logic [COLUMNS_DEF-1:0] shadow_frames [FRAMES_DEF*ROWS_DEF] = '{default: '0};
	logic [2:0]             shadow_scan_row    = '0;
	logic [2:0]             shadow_disp_mode   = MODE_IDLE;
	logic [15:0]            shadow_tick_cnt    = '0;
	logic [7:0]             shadow_scroll_div  = '0;
	logic [4:0]             shadow_scroll_pos  = '0;
	logic                   shadow_blink       = 1'b0;
	logic [9:0]             shadow_blink_div   = '0;
	logic [15:0]            shadow_startup_cnt = '0;
	logic                   shadow_sw_run      = 1'b0;
	logic [9:0]             shadow_sw_ms       = '0;
	logic [15:0]            shadow_sw_sec      = '0;
	digits_t                shadow_digits      = '0;

	matrix_item_t   pending_q[$];
	matrix_result_t expected_q[$];
	matrix_result_t front_result;
	int unsigned    fail_count  = 0;
	int unsigned    cycle_count = 0;
	int             burst_left  = 0;
	int             gap_left    = 0;
	int             hold_left   = 0;
	int             holds_done  = 0;
	int             stretch_left = 0;
	int             ready_pct   = 100;
	int unsigned    taken_count = 0;

	function automatic matrix_result_t step_matrix(matrix_item_t it);
		matrix_result_t r;
		r = '0;
		case (it.kind)
			KIND_TICK: begin
				r.drive_valid = 1'b1;
				r.row_select  = shadow_scan_row;
				if (shadow_disp_mode < FRAMES_DEF)
					r.column_bits = shadow_frames[shadow_disp_mode * ROWS_DEF + shadow_scan_row];
				shadow_scan_row = (shadow_scan_row + 1 >= ROWS_DEF) ? '0 : shadow_scan_row + 3'd1;
				shadow_tick_cnt++;
				if (shadow_disp_mode inside {MODE_SCROLL_TO_STATIC, MODE_SCROLL_TO_IDLE,
						MODE_STARTUP_SCROLL}) begin
					if (shadow_scroll_div == set_scroll_period) begin
						shadow_scroll_div = '0;
						if (shadow_scroll_pos == set_last_step) begin
							shadow_scroll_pos = '0;
							shadow_disp_mode = (shadow_disp_mode == MODE_SCROLL_TO_STATIC) ?
								MODE_STATIC : MODE_IDLE;
						end else begin
							shadow_scroll_pos++;
						end
					end
				end else begin
					shadow_scroll_div = '0;
					shadow_scroll_pos = '0;
				end
				shadow_scroll_div++;
				shadow_blink_div++;
				if (shadow_blink_div == set_blink_half) begin
					shadow_blink_div = '0;
					shadow_blink = ~shadow_blink;
				end
				if (shadow_disp_mode == MODE_STARTUP) begin
					shadow_startup_cnt++;
					if (shadow_startup_cnt == set_startup_hold)
						shadow_disp_mode = MODE_STARTUP_SCROLL;
				end
				if (shadow_disp_mode == MODE_STOPWATCH) begin
					if (shadow_sw_run) begin
						shadow_sw_ms++;
						if (shadow_sw_ms >= set_ms_per_sec) begin
							shadow_sw_ms = '0;
							shadow_sw_sec++;
						end
					end
					shadow_digits.minutes_tens  = 7'(shadow_sw_sec / 600);
					shadow_digits.minutes_units = 4'((shadow_sw_sec % 600) / 60);
					shadow_digits.seconds_tens  = 3'((shadow_sw_sec % 60) / 10);
					shadow_digits.seconds_units = 4'(shadow_sw_sec % 10);
				end
			end
			KIND_ROW_WRITE: begin
				if (it.frame < FRAMES_DEF && it.row < ROWS_DEF)
					shadow_frames[it.frame * ROWS_DEF + it.row] = it.bits;
			end
			KIND_SET_MODE: begin
				shadow_disp_mode = it.new_mode;
			end
			default: begin
				shadow_sw_run = it.run;
				if (it.clr) begin
					shadow_sw_sec = '0;
					shadow_sw_ms = '0;
				end
			end
		endcase
		r.display_mode = shadow_disp_mode;
		r.scroll_step  = shadow_scroll_pos;
		r.blink        = shadow_blink;
		r.tick_count   = shadow_tick_cnt;
		r.digits       = shadow_digits;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, longint unsigned got, longint unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			bus_item <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_q.push_back(step_matrix(bus_item));
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || pending_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					bus_item <= pending_q.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Receiver: stretches of differing readiness plus two long hold-offs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				taken_count++;
			if (hold_left == 0 && holds_done < 2 && taken_count >= 150 + 500 * holds_done) begin
				hold_left = 150;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (stretch_left > 0) begin
					stretch_left--;
				end else begin
					stretch_left = $urandom_range(16, 96);
					case ($urandom_range(0, 2))
						0: ready_pct = 100;
						1: ready_pct = 70;
						default: ready_pct = 35;
					endcase
				end
				out_ready <= ($urandom_range(0, 99) < ready_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with no transaction waiting");
			end else begin
				front_result = expected_q.pop_front();
				check_field("drive_valid", drive_valid, front_result.drive_valid);
				check_field("row_select", row_select, front_result.row_select);
				check_field("column_bits", column_bits, front_result.column_bits);
				check_field("display_mode", display_mode, front_result.display_mode);
				check_field("scroll_step", scroll_step, front_result.scroll_step);
				check_field("blink", blink, front_result.blink);
				check_field("tick_count", tick_count, front_result.tick_count);
				check_field("minutes_tens", minutes_tens, front_result.digits.minutes_tens);
				check_field("minutes_units", minutes_units, front_result.digits.minutes_units);
				check_field("seconds_tens", seconds_tens, front_result.digits.seconds_tens);
				check_field("seconds_units", seconds_units, front_result.digits.seconds_units);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL led_matrix_scan_mode_controller_top");
			$finish;
		end
	end

	function automatic matrix_item_t make_item(item_kind_t kind, logic [2:0] frame,
			logic [2:0] row, logic [COLUMNS_DEF-1:0] bits, logic [2:0] new_mode,
			logic run, logic clr);
		matrix_item_t it;
		it.kind     = kind;
		it.frame    = frame;
		it.row      = row;
		it.bits     = bits;
		it.new_mode = new_mode;
		it.run      = run;
		it.clr      = clr;
		return it;
	endfunction

	function automatic matrix_item_t rand_item(item_kind_t kind);
		return make_item(kind, 3'($urandom), 3'($urandom), COLUMNS_DEF'($urandom),
			3'($urandom), 1'($urandom), 1'($urandom));
	endfunction

	task automatic wait_drained();
		do @(negedge clk); while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [15:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SCROLL_PERIOD:     set_scroll_period = data[7:0];
			REG_LAST_SCROLL_STEP:  set_last_step     = data[4:0];
			REG_BLINK_HALF_PERIOD: set_blink_half    = data[9:0];
			REG_INIT_HOLD_TICKS:   set_startup_hold  = data;
			REG_TICKS_PER_SECOND:  set_ms_per_sec    = data[9:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Drains the block, then loads all five registers; unused upper data bits are random.
	task automatic load_settings(int sp, int ls, int bh, int ih, int tps);
		wait_drained();
		write_register(REG_SCROLL_PERIOD, {8'($urandom), 8'(sp)});
		write_register(REG_LAST_SCROLL_STEP, {11'($urandom), 5'(ls)});
		write_register(REG_BLINK_HALF_PERIOD, {6'($urandom), 10'(bh)});
		write_register(REG_INIT_HOLD_TICKS, 16'(ih));
		write_register(REG_TICKS_PER_SECOND, {6'($urandom), 10'(tps)});
		@(negedge clk);
	endtask

	// Mostly a display mode followed by a run of ticks, mixed with row writes,
	// stopwatch sets and the odd item of any kind.
	task automatic queue_scan_sessions(int count);
		int queued;
		int pick;
		queued = 0;
		while (queued < count) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				pending_q.push_back(rand_item(item_kind_t'($urandom_range(0, 3))));
				queued++;
			end else if (pick <= 2) begin
				repeat ($urandom_range(1, 4)) begin
					pending_q.push_back(rand_item(KIND_ROW_WRITE));
					queued++;
				end
			end else if (pick == 3) begin
				pending_q.push_back(rand_item(KIND_SET_STOPWATCH));
				queued++;
			end else begin
				pending_q.push_back(rand_item(KIND_SET_MODE));
				queued++;
				repeat ($urandom_range(4, 30)) begin
					pending_q.push_back(rand_item(KIND_TICK));
					queued++;
				end
			end
		end
	endtask

	task automatic queue_ticks(int count);
		repeat (count) pending_q.push_back(rand_item(KIND_TICK));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset settings.
		pending_q.push_back(make_item(KIND_TICK, '0, '0, '0, '0, 1'b0, 1'b0));
		pending_q.push_back(make_item(KIND_ROW_WRITE, 3'd0, 3'd0, 24'hFFFFFF, '0, 1'b0, 1'b0));
		pending_q.push_back(make_item(KIND_ROW_WRITE, 3'd0, 3'd1, 24'hA5A5A5, '0, 1'b0, 1'b0));
		pending_q.push_back(make_item(KIND_ROW_WRITE, 3'd7, 3'd7, 24'h800001, '0, 1'b0, 1'b0));
		pending_q.push_back(make_item(KIND_ROW_WRITE, 3'd1, 3'd2, 24'h5A5A5A, '0, 1'b0, 1'b0));
		queue_ticks(2);
		pending_q.push_back(make_item(KIND_SET_MODE, '0, '0, '0, MODE_STATIC, 1'b0, 1'b0));
		queue_ticks(2);
		pending_q.push_back(make_item(KIND_SET_MODE, '0, '0, '0, MODE_STOPWATCH, 1'b0, 1'b0));
		pending_q.push_back(make_item(KIND_SET_STOPWATCH, '0, '0, '0, '0, 1'b1, 1'b0));
		queue_ticks(2);
		pending_q.push_back(make_item(KIND_SET_STOPWATCH, '0, '0, '0, '0, 1'b0, 1'b1));
		queue_ticks(1);
		pending_q.push_back(make_item(KIND_SET_MODE, '0, '0, '0, MODE_STARTUP, 1'b0, 1'b0));
		queue_ticks(1);
		pending_q.push_back(make_item(KIND_SET_MODE, '0, '0, '0, MODE_SCROLL_TO_STATIC,
			1'b0, 1'b0));
		queue_ticks(1);
		pending_q.push_back(make_item(KIND_SET_MODE, '0, '0, '0, MODE_SCROLL_TO_IDLE,
			1'b0, 1'b0));
		queue_ticks(1);
		pending_q.push_back(make_item(KIND_SET_MODE, '0, '0, '0, MODE_STARTUP_SCROLL,
			1'b0, 1'b0));
		queue_ticks(1);

		// Fast settings so that scrolls, blinks and start-up holds complete often.
		load_settings(1, 2, 1, 3, 1);
		queue_scan_sessions(300);

		load_settings(255, 31, 1023, 65535, 1023);
		queue_scan_sessions(200);

		// Zero scroll period, blink half and start-up hold match only after the counters wrap.
		load_settings(0, 0, 0, 0, 0);
		wait_drained();
		for (int i = int'(REG_TICKS_PER_SECOND) + 1; i < (1 << $bits(cfg_index)); i++)
			write_register(3'(i), 16'($urandom));
		@(negedge clk);
		queue_scan_sessions(300);

		load_settings($urandom_range(1, 4), $urandom_range(0, 5), $urandom_range(1, 20),
			$urandom_range(1, 40), $urandom_range(1, 6));
		queue_scan_sessions(300);

		// Short runs: one stopwatch second per tick, then start-up mode with a hold of
		// zero, which the never-cleared counter matches only after it wraps.
		load_settings(2, 4, 0, 0, 0);
		pending_q.push_back(make_item(KIND_SET_MODE, '0, '0, '0, MODE_STOPWATCH, 1'b0, 1'b0));
		pending_q.push_back(make_item(KIND_SET_STOPWATCH, '0, '0, '0, '0, 1'b1, 1'b1));
		queue_ticks(40);
		pending_q.push_back(make_item(KIND_SET_MODE, '0, '0, '0, MODE_STARTUP, 1'b0, 1'b0));
		queue_ticks(40);
		queue_scan_sessions(20);

		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
		if (fail_count == 0) begin
			$display("PASS led_matrix_scan_mode_controller_top");
		end else begin
			$display("FAIL led_matrix_scan_mode_controller_top");
		end
		$finish;
	end

endmodule
